// ===== src/stmd_pkg.sv =====
// ----------------------------------------------------------------------------
// stmd_pkg
// Shared types, codes and the 5x7 font for the scrolling text matrix driver.
// ----------------------------------------------------------------------------
package stmd_pkg;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic CSR_FRAMES_PER_STEP = 1'b0;
   localparam logic CSR_MSG_LEN         = 1'b1;

   localparam logic KIND_SHIFT = 1'b0;
   localparam logic KIND_LATCH = 1'b1;

   localparam logic [6:0] SPACE_CODE = 7'h20;
   localparam logic [6:0] FIRST_CODE = 7'h20;
   localparam logic [6:0] LAST_CODE  = 7'h7E;
   localparam logic [2:0] BLANK_ROW  = 3'd7;
   localparam logic [2:0] LAST_PULSE = 3'd5;

   localparam logic [7:0] FPS_RESET     = 8'd5;
   localparam logic [5:0] MSG_LEN_RESET = 6'd13;

   typedef struct packed {
      logic wr_char;
      logic start;
      logic reduce;
      logic load_char;
      logic emit_shift;
      logic next_char;
      logic emit_pad;
      logic emit_latch;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pos_ge_len;
      logic bit_last;
      logic char_last;
      logic pad_none;
      logic pad_last;
   } ctrl_sts_type;

   // Active-low glyph rows: a clear bit in [4:0] is lit, bit 4 leftmost.
   localparam logic [7:0] GLYPH [0:94][0:6] = '{
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFF, 8'hFB},
      '{8'hF5, 8'hF5, 8'hF5, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hF5, 8'hF5, 8'hE0, 8'hF5, 8'hE0, 8'hF5, 8'hF5},
      '{8'hFB, 8'hF0, 8'hEB, 8'hF1, 8'hFA, 8'hE1, 8'hFB},
      '{8'hE3, 8'hEA, 8'hE5, 8'hFB, 8'hF4, 8'hEA, 8'hF8},
      '{8'hF7, 8'hEB, 8'hEB, 8'hF7, 8'hEA, 8'hED, 8'hF2},
      '{8'hF9, 8'hF9, 8'hFD, 8'hFB, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFD, 8'hFB, 8'hF7, 8'hF7, 8'hF7, 8'hFB, 8'hFD},
      '{8'hF7, 8'hFB, 8'hFD, 8'hFD, 8'hFD, 8'hFB, 8'hF7},
      '{8'hFB, 8'hEA, 8'hF1, 8'hFB, 8'hF1, 8'hEA, 8'hFB},
      '{8'hFF, 8'hFB, 8'hFB, 8'hE0, 8'hFB, 8'hFB, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hF3, 8'hF3, 8'hFB, 8'hF7},
      '{8'hFF, 8'hFF, 8'hFF, 8'hF1, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF3, 8'hF3},
      '{8'hFF, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hFF},
      '{8'hF1, 8'hEE, 8'hEC, 8'hEA, 8'hE6, 8'hEE, 8'hF1},
      '{8'hFB, 8'hF3, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hF1},
      '{8'hF1, 8'hEE, 8'hFE, 8'hF1, 8'hEF, 8'hEF, 8'hE0},
      '{8'hF1, 8'hEE, 8'hFE, 8'hF9, 8'hFE, 8'hEE, 8'hF1},
      '{8'hFD, 8'hF9, 8'hF5, 8'hED, 8'hE0, 8'hFD, 8'hFD},
      '{8'hE0, 8'hEF, 8'hE1, 8'hFE, 8'hFE, 8'hFE, 8'hE1},
      '{8'hF9, 8'hF7, 8'hEF, 8'hE1, 8'hEE, 8'hEE, 8'hF1},
      '{8'hE0, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hF7, 8'hF7},
      '{8'hF1, 8'hEE, 8'hEE, 8'hF1, 8'hEE, 8'hEE, 8'hF1},
      '{8'hF1, 8'hEE, 8'hEE, 8'hF0, 8'hFE, 8'hFD, 8'hF3},
      '{8'hFF, 8'hF3, 8'hF3, 8'hFF, 8'hF3, 8'hF3, 8'hFF},
      '{8'hF3, 8'hFB, 8'hF3, 8'hF3, 8'hFF, 8'hF3, 8'hF3},
      '{8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hF7, 8'hFB, 8'hFD},
      '{8'hFF, 8'hFF, 8'hF1, 8'hFF, 8'hF1, 8'hFF, 8'hFF},
      '{8'hF7, 8'hFB, 8'hFD, 8'hFE, 8'hFD, 8'hFB, 8'hF7},
      '{8'hF1, 8'hEE, 8'hFE, 8'hFD, 8'hFB, 8'hFF, 8'hFB},
      '{8'hF1, 8'hEE, 8'hFE, 8'hF2, 8'hEA, 8'hEA, 8'hF1},
      '{8'hFB, 8'hF5, 8'hEE, 8'hEE, 8'hE0, 8'hEE, 8'hEE},
      '{8'hE1, 8'hF6, 8'hF6, 8'hF1, 8'hF6, 8'hF6, 8'hE1},
      '{8'hF1, 8'hEE, 8'hEF, 8'hEF, 8'hEF, 8'hEE, 8'hF1},
      '{8'hE1, 8'hF6, 8'hF6, 8'hF6, 8'hF6, 8'hF6, 8'hE1},
      '{8'hE0, 8'hEF, 8'hEF, 8'hE3, 8'hEF, 8'hEF, 8'hE0},
      '{8'hE0, 8'hEF, 8'hEF, 8'hE3, 8'hEF, 8'hEF, 8'hEF},
      '{8'hF1, 8'hEE, 8'hEF, 8'hE8, 8'hEE, 8'hEE, 8'hF1},
      '{8'hEE, 8'hEE, 8'hEE, 8'hE0, 8'hEE, 8'hEE, 8'hEE},
      '{8'hF1, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hF1},
      '{8'hF8, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hF3},
      '{8'hEE, 8'hED, 8'hEB, 8'hE7, 8'hEB, 8'hED, 8'hEE},
      '{8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hEF, 8'hE0},
      '{8'hEE, 8'hE4, 8'hEA, 8'hEA, 8'hEE, 8'hEE, 8'hEE},
      '{8'hEE, 8'hE6, 8'hEA, 8'hEC, 8'hEE, 8'hEE, 8'hEE},
      '{8'hF1, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hF1},
      '{8'hE1, 8'hEE, 8'hEE, 8'hE1, 8'hEF, 8'hEF, 8'hEF},
      '{8'hF1, 8'hEE, 8'hEE, 8'hEE, 8'hEA, 8'hED, 8'hF2},
      '{8'hE1, 8'hEE, 8'hEE, 8'hE1, 8'hEB, 8'hED, 8'hEE},
      '{8'hF1, 8'hEE, 8'hEF, 8'hF1, 8'hFE, 8'hEE, 8'hF1},
      '{8'hE0, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB},
      '{8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hF1},
      '{8'hEE, 8'hEE, 8'hEE, 8'hF5, 8'hF5, 8'hFB, 8'hFB},
      '{8'hEE, 8'hEE, 8'hEE, 8'hEA, 8'hEA, 8'hE4, 8'hEE},
      '{8'hEE, 8'hEE, 8'hF5, 8'hFB, 8'hF5, 8'hEE, 8'hEE},
      '{8'hEE, 8'hEE, 8'hF5, 8'hFB, 8'hFB, 8'hFB, 8'hFB},
      '{8'hE0, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hE0},
      '{8'hF1, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF7, 8'hF1},
      '{8'hFF, 8'hEF, 8'hF7, 8'hFB, 8'hFD, 8'hFE, 8'hFF},
      '{8'hF1, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hFD, 8'hF1},
      '{8'hFB, 8'hF5, 8'hEE, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE0},
      '{8'hF3, 8'hF3, 8'hF7, 8'hFB, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'hFF, 8'hF1, 8'hFE, 8'hF0, 8'hEE, 8'hF1},
      '{8'hEF, 8'hEF, 8'hE9, 8'hE6, 8'hEE, 8'hE6, 8'hE9},
      '{8'hFF, 8'hFF, 8'hF8, 8'hF7, 8'hF7, 8'hF7, 8'hF8},
      '{8'hFE, 8'hFE, 8'hF2, 8'hEC, 8'hEE, 8'hEC, 8'hF2},
      '{8'hFF, 8'hFF, 8'hF1, 8'hEE, 8'hE0, 8'hEF, 8'hF1},
      '{8'hF9, 8'hF6, 8'hF7, 8'hE1, 8'hF7, 8'hF7, 8'hF7},
      '{8'hFF, 8'hFF, 8'hF0, 8'hEE, 8'hF0, 8'hFE, 8'hF1},
      '{8'hEF, 8'hEF, 8'hE9, 8'hE6, 8'hEE, 8'hEE, 8'hEE},
      '{8'hFB, 8'hFF, 8'hF3, 8'hFB, 8'hFB, 8'hFB, 8'hF1},
      '{8'hFD, 8'hFF, 8'hF9, 8'hFD, 8'hFD, 8'hFD, 8'hF3},
      '{8'hF7, 8'hF7, 8'hF6, 8'hF5, 8'hF3, 8'hF5, 8'hF6},
      '{8'hF3, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hFB, 8'hF1},
      '{8'hFF, 8'hFF, 8'hE5, 8'hEA, 8'hEA, 8'hEA, 8'hEA},
      '{8'hFF, 8'hFF, 8'hE9, 8'hE6, 8'hEE, 8'hEE, 8'hEE},
      '{8'hFF, 8'hFF, 8'hF1, 8'hEE, 8'hEE, 8'hEE, 8'hF1},
      '{8'hFF, 8'hFF, 8'hE1, 8'hEE, 8'hE1, 8'hEF, 8'hEF},
      '{8'hFF, 8'hFF, 8'hF0, 8'hEE, 8'hF0, 8'hFE, 8'hFE},
      '{8'hFF, 8'hFF, 8'hE9, 8'hE6, 8'hEF, 8'hEF, 8'hEF},
      '{8'hFF, 8'hFF, 8'hF0, 8'hEF, 8'hF1, 8'hFE, 8'hE1},
      '{8'hFB, 8'hFB, 8'hF0, 8'hFB, 8'hFB, 8'hFB, 8'hFC},
      '{8'hFF, 8'hFF, 8'hEE, 8'hEE, 8'hEE, 8'hEC, 8'hF2},
      '{8'hFF, 8'hFF, 8'hEE, 8'hEE, 8'hEE, 8'hF5, 8'hFB},
      '{8'hFF, 8'hFF, 8'hEE, 8'hEE, 8'hEA, 8'hEA, 8'hF4},
      '{8'hFF, 8'hFF, 8'hEE, 8'hF5, 8'hFB, 8'hF5, 8'hEE},
      '{8'hFF, 8'hFF, 8'hEE, 8'hF5, 8'hFB, 8'hFB, 8'hF3},
      '{8'hFF, 8'hFF, 8'hE0, 8'hFD, 8'hFB, 8'hF7, 8'hE0},
      '{8'hF9, 8'hF7, 8'hF7, 8'hE7, 8'hF7, 8'hF7, 8'hF9},
      '{8'hFB, 8'hFB, 8'hFB, 8'hFF, 8'hFB, 8'hFB, 8'hFB},
      '{8'hF3, 8'hFD, 8'hFD, 8'hFC, 8'hFD, 8'hFD, 8'hF3},
      '{8'hF5, 8'hEA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
   };

   function automatic logic [4:0] glyph_pixels(input logic [6:0] code,
                                                input logic [2:0] row);
      logic [6:0] idx;
      logic [7:0] bits;
      idx = code - FIRST_CODE;
      if (row == BLANK_ROW || code < FIRST_CODE || code > LAST_CODE) begin
         return 5'd0;
      end
      bits = GLYPH[idx][row];
      return ~bits[4:0];
   endfunction

endpackage

// ===== src/stmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// stmd_ctrl
// Sequencer for character writes and for one row refresh: offset reduce,
// first fetch, pixel beats, pad beats and the latch beat.
// ----------------------------------------------------------------------------
module stmd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_cmd,
   input  stmd_pkg::ctrl_sts_type sts,
   output stmd_pkg::ctrl_cmd_type cmd
);
   import stmd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_PAD    = 3'd4;
   localparam logic [2:0] S_LATCH  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.wr_char = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (sts.pos_ge_len) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_char = 1'b1;
            state_in      = S_SHIFT;
         end
         S_SHIFT: begin
            if (sts.out_free) begin
               cmd.emit_shift = 1'b1;
               if (sts.bit_last) begin
                  if (!sts.char_last) begin
                     cmd.next_char = 1'b1;
                  end else if (sts.pad_none) begin
                     state_in = S_LATCH;
                  end else begin
                     state_in = S_PAD;
                  end
               end
            end
         end
         S_PAD: begin
            if (sts.out_free) begin
               cmd.emit_pad = 1'b1;
               if (sts.pad_last) begin
                  state_in = S_LATCH;
               end
            end
         end
         S_LATCH: begin
            if (sts.out_free) begin
               cmd.emit_latch = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/stmd_datapath.sv =====
// ----------------------------------------------------------------------------
// stmd_datapath
// Message store, scroll state, pixel shifter, beat counters and the
// output register.
// ----------------------------------------------------------------------------
module stmd_datapath #(
   parameter int TEXT_DEPTH    = 32,
   parameter int VISIBLE_CHARS = 8,
   parameter int SHIFT_STEPS   = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stmd_pkg::ctrl_cmd_type cmd,
   output stmd_pkg::ctrl_sts_type sts,
   input  logic [4:0]             char_index,
   input  logic [6:0]             char_code,
   input  logic                   csr_we,
   input  logic                   csr_addr,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_kind,
   output logic                   rsp_serial_data,
   output logic [7:0]             rsp_row_code,
   output logic                   rsp_last
);
   import stmd_pkg::*;

   localparam int AW  = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
   localparam int LW0 = $clog2(TEXT_DEPTH + 1);
   localparam int LW  = (LW0 > 6) ? LW0 : 6;
   localparam int CCW = (VISIBLE_CHARS > 1) ? $clog2(VISIBLE_CHARS) : 1;

   logic [6:0]            mem [TEXT_DEPTH];
   logic [TEXT_DEPTH-1:0] vld_ff;
   logic [6:0]            rd_code_ff;
   logic                  rd_vld_ff;

   logic [7:0]     fps_ff;
   logic [5:0]     msg_len_ff;
   logic [LW-1:0]  len_ff,         len_in;
   logic [AW-1:0]  pos_ff,         pos_in;
   logic [5:0]     sr_ff,          sr_in;
   logic [2:0]     bit_cnt_ff,     bit_cnt_in;
   logic [CCW-1:0] char_cnt_ff,    char_cnt_in;
   logic [2:0]     pad_cnt_ff,     pad_cnt_in;
   logic [2:0]     row_index_ff,   row_index_in;
   logic [7:0]     frame_cnt_ff,   frame_cnt_in;
   logic [2:0]     pix_off_ff,     pix_off_in;
   logic [AW-1:0]  char_off_ff,    char_off_in;
   logic [7:0]     row_cnt_ff,     row_cnt_in;
   logic           out_vld_ff,     out_vld_in;
   logic           out_kind_ff,    out_kind_in;
   logic           out_data_ff,    out_data_in;
   logic [7:0]     out_code_ff,    out_code_in;
   logic           out_last_ff,    out_last_in;

   logic [LW-1:0] eff_len;
   logic [LW-1:0] pos_inc;
   logic [AW-1:0] pos_adv;
   logic [LW-1:0] co_inc;
   logic [7:0]    frame_inc;
   logic [2:0]    pix_inc;
   logic [6:0]    cur_code;
   logic [4:0]    cur_pix;
   logic          idx_ok;
   logic [AW-1:0] wr_addr;

   assign idx_ok  = int'(char_index) < TEXT_DEPTH;
   assign wr_addr = AW'(char_index);

   always_comb begin
      eff_len = LW'(msg_len_ff);
      if (msg_len_ff == 6'd0) begin
         eff_len = LW'(1);
      end else if (eff_len > LW'(TEXT_DEPTH)) begin
         eff_len = LW'(TEXT_DEPTH);
      end
   end

   assign pos_inc   = LW'(pos_ff) + LW'(1);
   assign pos_adv   = (pos_inc >= len_ff) ? '0 : AW'(pos_inc);
   assign co_inc    = LW'(char_off_ff) + LW'(1);
   assign frame_inc = frame_cnt_ff + 8'd1;
   assign pix_inc   = pix_off_ff + 3'd1;
   assign cur_code  = rd_vld_ff ? rd_code_ff : SPACE_CODE;
   assign cur_pix   = glyph_pixels(cur_code, row_index_ff);

   always_comb begin
      sts.out_free   = !out_vld_ff || rsp_tready;
      sts.pos_ge_len = LW'(pos_ff) >= len_ff;
      sts.bit_last   = (bit_cnt_ff == LAST_PULSE);
      sts.char_last  = (char_cnt_ff == CCW'(VISIBLE_CHARS - 1));
      sts.pad_none   = (pix_off_ff == 3'd0);
      sts.pad_last   = ((pad_cnt_ff + 3'd1) == pix_off_ff);
   end

   always_comb begin
      len_in       = len_ff;
      pos_in       = pos_ff;
      sr_in        = sr_ff;
      bit_cnt_in   = bit_cnt_ff;
      char_cnt_in  = char_cnt_ff;
      pad_cnt_in   = pad_cnt_ff;
      row_index_in = row_index_ff;
      frame_cnt_in = frame_cnt_ff;
      pix_off_in   = pix_off_ff;
      char_off_in  = char_off_ff;
      row_cnt_in   = row_cnt_ff;
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;

      if (cmd.start) begin
         len_in      = eff_len;
         pos_in      = char_off_ff;
         char_cnt_in = '0;
         pad_cnt_in  = 3'd0;
      end
      if (cmd.reduce) begin
         pos_in = AW'(LW'(pos_ff) - len_ff);
      end
      if (cmd.load_char) begin
         sr_in      = {1'b0, cur_pix};
         pos_in     = pos_adv;
         bit_cnt_in = 3'd0;
      end
      if (cmd.emit_shift) begin
         out_vld_in  = 1'b1;
         out_kind_in = KIND_SHIFT;
         out_data_in = sr_ff[5];
         out_code_in = 8'd0;
         out_last_in = 1'b0;
         sr_in       = {sr_ff[4:0], 1'b0};
         bit_cnt_in  = sts.bit_last ? 3'd0 : bit_cnt_ff + 3'd1;
      end
      if (cmd.next_char) begin
         sr_in       = {1'b0, cur_pix};
         pos_in      = pos_adv;
         char_cnt_in = char_cnt_ff + CCW'(1);
      end
      if (cmd.emit_pad) begin
         out_vld_in  = 1'b1;
         out_kind_in = KIND_SHIFT;
         out_data_in = 1'b0;
         out_code_in = 8'd0;
         out_last_in = 1'b0;
         pad_cnt_in  = pad_cnt_ff + 3'd1;
      end
      if (cmd.emit_latch) begin
         out_vld_in   = 1'b1;
         out_kind_in  = KIND_LATCH;
         out_data_in  = 1'b0;
         out_code_in  = row_cnt_ff + 8'd1;
         out_last_in  = 1'b1;
         row_cnt_in   = row_cnt_ff + 8'd1;
         row_index_in = row_index_ff + 3'd1;
         if (row_index_ff == BLANK_ROW) begin
            frame_cnt_in = frame_inc;
            if (frame_inc == fps_ff) begin
               frame_cnt_in = 8'd0;
               pix_off_in   = pix_inc;
               if (pix_inc >= 3'(SHIFT_STEPS)) begin
                  pix_off_in  = 3'd0;
                  char_off_in = (co_inc >= len_ff) ? '0 : AW'(co_inc);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff       <= FPS_RESET;
         msg_len_ff   <= MSG_LEN_RESET;
         vld_ff       <= '0;
         row_index_ff <= 3'd0;
         frame_cnt_ff <= 8'd0;
         pix_off_ff   <= 3'd0;
         char_off_ff  <= '0;
         row_cnt_ff   <= 8'd0;
         out_vld_ff   <= 1'b0;
         bit_cnt_ff   <= 3'd0;
         char_cnt_ff  <= '0;
         pad_cnt_ff   <= 3'd0;
         pos_ff       <= '0;
         len_ff       <= LW'(1);
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_FRAMES_PER_STEP: fps_ff     <= csr_wdata;
               CSR_MSG_LEN:         msg_len_ff <= csr_wdata[5:0];
            endcase
         end
         if (cmd.wr_char && idx_ok) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         row_index_ff <= row_index_in;
         frame_cnt_ff <= frame_cnt_in;
         pix_off_ff   <= pix_off_in;
         char_off_ff  <= char_off_in;
         row_cnt_ff   <= row_cnt_in;
         out_vld_ff   <= out_vld_in;
         bit_cnt_ff   <= bit_cnt_in;
         char_cnt_ff  <= char_cnt_in;
         pad_cnt_ff   <= pad_cnt_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff       <= sr_in;
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_char && idx_ok) begin
         mem[wr_addr] <= char_code;
      end
      rd_code_ff <= mem[pos_ff];
      rd_vld_ff  <= vld_ff[pos_ff];
   end

   assign rsp_tvalid      = out_vld_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_serial_data = out_data_ff;
   assign rsp_row_code    = out_code_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== src/scrolling_text_matrix_driver.sv =====
// ----------------------------------------------------------------------------
// scrolling_text_matrix_driver
// Scrolling text driver for a shift-register LED matrix with a 5x7 font.
// ----------------------------------------------------------------------------
// A write beat (tuser 1) stores one character. A tick beat (tuser 0)
// refreshes one row and returns 6*VISIBLE_CHARS pixel beats, then
// pixel_offset blank beats, then one latch beat with tlast; the sequencer
// puts out one beat per cycle while the output is not held by
// backpressure. Before the first fetch, the length is subtracted from the
// scroll offset as often as needed when the offset lies past a shortened
// message. The message store is a memory with one read port, read every
// cycle at the current position; unwritten entries read as spaces. The
// next beat is taken once the last result of the tick has been loaded
// into the output register.
// ----------------------------------------------------------------------------
module scrolling_text_matrix_driver #(
   parameter int TEXT_DEPTH    = 32,
   parameter int VISIBLE_CHARS = 8,
   parameter int SHIFT_STEPS   = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_index[4:0], char_code[11:5], zero
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // serial_data[0], row_code[8:1], zero
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);
   import stmd_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         serial_data;
   logic [7:0]   row_code;

   stmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   stmd_datapath #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .VISIBLE_CHARS (VISIBLE_CHARS),
      .SHIFT_STEPS   (SHIFT_STEPS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .char_index      (req_tdata[4:0]),
      .char_code       (req_tdata[11:5]),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_kind        (rsp_tuser),
      .rsp_serial_data (serial_data),
      .rsp_row_code    (row_code),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, row_code, serial_data};

endmodule
